>>> src/pauli_shadow_expectation_accumulator_assert.svh
// Assertion macros shared by the checker of the Pauli shadow accumulator
`ifndef PAULI_SHADOW_EXPECTATION_ACCUMULATOR_ASSERT_SVH
`define PAULI_SHADOW_EXPECTATION_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define PSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pse assertion failed");

// Next-cycle implication, disabled in reset
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pse assertion failed");

`endif

>>> src/pse_pkg.sv
// Types, constants and codes of the Pauli shadow expectation accumulator
package pse_pkg;

    localparam int MAX_QUBITS   = 32;
    localparam int TABLE_DEPTH  = 256;
    localparam int COUNT_BITS   = 24;
    localparam int NUM_CELLS    = 16;
    localparam int CELL_DEPTH   = TABLE_DEPTH / NUM_CELLS;
    localparam int CELL_W       = $clog2(NUM_CELLS);
    localparam int SLOT_W       = $clog2(CELL_DEPTH);
    localparam int INDEX_W      = CELL_W + SLOT_W;
    localparam int PAULI_W      = 2 * MAX_QUBITS;
    localparam int QCOUNT_W     = 6;
    localparam int OCOUNT_W     = 9;
    localparam int SUM_W        = COUNT_BITS + 1;
    localparam int QUOT_W       = 17;
    localparam int EXP_W        = 18;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 9;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [SLOT_W-1:0]     SLOT_LAST   = SLOT_W'(CELL_DEPTH - 1);
    localparam logic [QCOUNT_W-1:0]   QCOUNT_RST  = QCOUNT_W'(MAX_QUBITS);
    localparam logic [OCOUNT_W-1:0]   OCOUNT_FULL = OCOUNT_W'(TABLE_DEPTH);

    // Pauli codes
    localparam logic [1:0] PAULI_I = 2'd0;
    localparam logic [1:0] PAULI_X = 2'd1;
    localparam logic [1:0] PAULI_Y = 2'd2;
    localparam logic [1:0] PAULI_Z = 2'd3;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_SNAP = 2'd1,
        MODE_READ = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUBIT_COUNT = 1'b0,
        CFG_OBS_COUNT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SNAP,
        ST_DRAIN,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DIV,
        ST_FIN
    } t_state;

    // Snapshot token walking down the cell chain
    typedef struct packed {
        logic                  valid;
        logic [SLOT_W-1:0]     slot;
        logic [PAULI_W-1:0]    bases;
        logic [MAX_QUBITS-1:0] signs;
        logic [MAX_QUBITS-1:0] qmask;
    } t_tok;

    // One table entry as stored in a cell
    typedef struct packed {
        logic [PAULI_W-1:0]       pauli;
        logic [COUNT_BITS-1:0]    count;
        logic signed [SUM_W-1:0]  sum;
    } t_entry;

    // Entry load request to one cell
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [PAULI_W-1:0] pauli;
    } t_wr;

    // Readout request broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
    } t_rd;

endpackage

>>> src/pse_in_if.sv
// Input channel interface: valid/ready plus one input transaction
interface pse_in_if;
    import pse_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [7:0]            entry_index;
    logic [PAULI_W-1:0]    pauli_string;
    logic [PAULI_W-1:0]    snapshot_bases;
    logic [MAX_QUBITS-1:0] snapshot_signs;

    modport source (
        output valid, mode, entry_index, pauli_string, snapshot_bases, snapshot_signs,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, pauli_string, snapshot_bases, snapshot_signs,
        output ready
    );
endinterface

>>> src/pse_out_if.sv
// Output channel interface: valid/ready plus one readout transaction
interface pse_out_if;
    import pse_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [7:0]              result_index;
    logic                    index_valid;
    logic [COUNT_BITS-1:0]   match_total;
    logic signed [SUM_W-1:0] sign_sum;
    logic signed [EXP_W-1:0] expectation;

    modport source (
        output valid, result_index, index_valid, match_total, sign_sum, expectation,
        input  ready
    );
    modport sink (
        input  valid, result_index, index_valid, match_total, sign_sum, expectation,
        output ready
    );
endinterface

>>> src/pse_ram.sv
// Generic simple dual-port RAM, one write and one registered read port
module pse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/pse_cell.sv
// One chain cell: holds a slice of the observable table and updates it per snapshot
module pse_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pse_pkg::CELL_W-1:0]   i_cell_id,
    input  logic [pse_pkg::OCOUNT_W-1:0] i_limit,
    input  pse_pkg::t_tok                i_tok,
    output pse_pkg::t_tok                o_tok,
    input  pse_pkg::t_wr                 i_load,
    input  pse_pkg::t_rd                 i_rd,
    output pse_pkg::t_entry              o_rdata
);
    import pse_pkg::*;

    t_tok               r_tok;
    t_entry             w_rdata;
    t_entry             w_wdata;
    t_entry             w_upd;
    logic [SLOT_W-1:0]  w_raddr;
    logic [SLOT_W-1:0]  w_waddr;
    logic               w_we;
    logic               w_mismatch;
    logic               w_parity;
    logic               w_in_use;
    logic               w_hit;
    logic [$bits(t_entry)-1:0] w_rdata_raw;

    // token register: hands the snapshot to the next cell in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.slot  <= i_tok.slot;
        r_tok.bases <= i_tok.bases;
        r_tok.signs <= i_tok.signs;
        r_tok.qmask <= i_tok.qmask;
    end

    assign o_tok = r_tok;

    // read port serves readout or the snapshot sweep
    assign w_raddr = i_rd.en ? i_rd.slot : i_tok.slot;

    pse_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CELL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    assign w_rdata = t_entry'(w_rdata_raw);
    assign o_rdata = w_rdata;

    // per-qubit match and outcome parity
    always_comb begin
        w_mismatch = 1'b0;
        w_parity   = 1'b0;
        for (int q = 0; q < MAX_QUBITS; q++) begin
            if (r_tok.qmask[q] && (w_rdata.pauli[2*q +: 2] != PAULI_I)) begin
                w_mismatch = w_mismatch | (w_rdata.pauli[2*q +: 2] != r_tok.bases[2*q +: 2]);
                w_parity   = w_parity ^ r_tok.signs[q];
            end
        end
    end

    assign w_in_use = {1'b0, i_cell_id, r_tok.slot} < i_limit;
    assign w_hit    = r_tok.valid && w_in_use && !w_mismatch && (w_rdata.count != COUNT_MAX);

    // updated counters
    always_comb begin
        w_upd       = w_rdata;
        w_upd.count = w_rdata.count + COUNT_BITS'(1);
        w_upd.sum   = w_parity ? (w_rdata.sum - SUM_W'(1)) : (w_rdata.sum + SUM_W'(1));
    end

    // write port: entry load or snapshot write-back
    always_comb begin
        if (i_load.en) begin
            w_we          = 1'b1;
            w_waddr       = i_load.slot;
            w_wdata.pauli = i_load.pauli;
            w_wdata.count = '0;
            w_wdata.sum   = '0;
        end else begin
            w_we    = w_hit;
            w_waddr = r_tok.slot;
            w_wdata = w_upd;
        end
    end
endmodule

>>> src/pse_div.sv
// Restoring divider for the expectation: quotient of (a * 65536) / d, one bit per cycle
module pse_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pse_pkg::COUNT_BITS-1:0] i_dividend,
    input  logic [pse_pkg::COUNT_BITS-1:0] i_divisor,
    output logic                           o_done,
    output logic [pse_pkg::QUOT_W-1:0]     o_quot
);
    import pse_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [QUOT_W-1:0]     r_bits;
    logic [QUOT_W-1:0]     r_quot;
    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_ge;

    // the quotient stays below 2^17 because |a| <= d, so the upper dividend
    // bits form the starting remainder and only 17 bits need stepping
    assign w_trial = {r_rem, r_bits[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_step <= STEP_W'(QUOT_W - 1);
            r_rem  <= {1'b0, i_dividend[COUNT_BITS-1:1]};
            r_bits <= {i_dividend[0], {(QUOT_W-1){1'b0}}};
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            r_rem  <= w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            r_bits <= {r_bits[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> src/pauli_shadow_expectation_accumulator.sv
// Top level: control, configuration and the chain of table cells
// Load: stays in the idle state, so the next transaction may follow at once.
// Snapshot: 16 cells of 16 entries each; the token is fed into the chain slot by slot
//   and passes each cell's token register until the last slot leaves the last cell.
// Readout: RD_ADDR, RD_DATA, the 17-step divider if needed, then FIN to the output.
// Synchronous active-low reset clears control and configuration; table contents are
//   not cleared and an entry is defined once loaded.
module pauli_shadow_expectation_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pse_in_if.sink                         i_in,
    pse_out_if.source                      o_out
);
    import pse_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [QCOUNT_W-1:0]     r_qubit_count;
    logic [OCOUNT_W-1:0]     r_obs_count;
    logic [OCOUNT_W-1:0]     w_limit;
    logic [QCOUNT_W-1:0]     w_nq;
    logic [MAX_QUBITS-1:0]   w_qmask;
    logic                    w_accept;

    logic                    r_ld_vld;
    logic [INDEX_W-1:0]      r_ld_idx;
    logic [PAULI_W-1:0]      r_ld_pauli;

    logic [PAULI_W-1:0]      r_bases;
    logic [MAX_QUBITS-1:0]   r_signs;
    logic [MAX_QUBITS-1:0]   r_qmask;
    logic [SLOT_W-1:0]       r_slot;

    logic [INDEX_W-1:0]      r_idx;
    logic                    r_ivalid;
    logic [COUNT_BITS-1:0]   r_cnt;
    logic signed [SUM_W-1:0] r_sum;

    logic                    r_out_valid;
    logic [INDEX_W-1:0]      r_out_index;
    logic                    r_out_ivalid;
    logic [COUNT_BITS-1:0]   r_out_total;
    logic signed [SUM_W-1:0] r_out_sum;
    logic signed [EXP_W-1:0] r_out_exp;

    t_tok                    w_tok [NUM_CELLS+1];
    t_wr                     w_load [NUM_CELLS];
    t_entry                  w_rdata [NUM_CELLS];
    t_rd                     w_rd;
    t_entry                  w_sel;
    logic                    w_rd_valid;
    logic                    w_div_start;
    logic [SUM_W-1:0]        w_abs;
    logic                    w_div_done;
    logic [QUOT_W-1:0]       w_quot;
    logic signed [EXP_W-1:0] w_exp;
    logic                    w_out_free;

    // effective counts from configuration
    assign w_limit = (r_obs_count > OCOUNT_FULL) ? OCOUNT_FULL : r_obs_count;
    assign w_nq    = (r_qubit_count > QCOUNT_RST) ? QCOUNT_RST : r_qubit_count;

    always_comb begin
        for (int q = 0; q < MAX_QUBITS; q++) begin
            w_qmask[q] = QCOUNT_W'(q) < w_nq;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubit_count <= QCOUNT_RST;
            r_obs_count   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_QUBIT_COUNT: r_qubit_count <= i_cfg_data[QCOUNT_W-1:0];
                CFG_OBS_COUNT:   r_obs_count   <= i_cfg_data[OCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    case (t_mode'(i_in.mode))
                        MODE_SNAP: n_state = ST_SNAP;
                        MODE_READ: n_state = ST_RD_ADDR;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SNAP: begin
                if (r_slot == SLOT_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_tok[NUM_CELLS].valid && (w_tok[NUM_CELLS].slot == SLOT_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_ADDR: n_state = ST_RD_DATA;
            ST_RD_DATA: n_state = w_div_start ? ST_DIV : ST_FIN;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // transaction capture and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_vld <= 1'b0;
        end else begin
            r_ld_vld <= w_accept && (i_in.mode == MODE_LOAD);
        end
        r_ld_idx   <= i_in.entry_index;
        r_ld_pauli <= i_in.pauli_string;
        if (w_accept) begin
            r_bases <= i_in.snapshot_bases;
            r_signs <= i_in.snapshot_signs;
            r_qmask <= w_qmask;
            r_slot  <= '0;
            r_idx   <= i_in.entry_index;
        end else if (r_state == ST_SNAP) begin
            r_slot  <= r_slot + SLOT_W'(1);
        end
        if (r_state == ST_RD_DATA) begin
            r_ivalid <= w_rd_valid;
            r_cnt    <= w_sel.count;
            r_sum    <= w_sel.sum;
        end
    end

    // token injected at the head of the chain
    always_comb begin
        w_tok[0].valid = (r_state == ST_SNAP);
        w_tok[0].slot  = r_slot;
        w_tok[0].bases = r_bases;
        w_tok[0].signs = r_signs;
        w_tok[0].qmask = r_qmask;
    end

    assign w_rd.en   = (r_state == ST_RD_ADDR);
    assign w_rd.slot = r_idx[SLOT_W-1:0];

    // chain of cells; entry e lives in cell e[7:4], slot e[3:0]
    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        assign w_load[j].en    = r_ld_vld && (r_ld_idx[INDEX_W-1:SLOT_W] == CELL_W'(j));
        assign w_load[j].slot  = r_ld_idx[SLOT_W-1:0];
        assign w_load[j].pauli = r_ld_pauli;

        pse_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_W'(j)),
            .i_limit   (w_limit),
            .i_tok     (w_tok[j]),
            .o_tok     (w_tok[j+1]),
            .i_load    (w_load[j]),
            .i_rd      (w_rd),
            .o_rdata   (w_rdata[j])
        );
    end

    // readout: select the cell, start the divider when there is something to divide
    assign w_sel       = w_rdata[r_idx[INDEX_W-1:SLOT_W]];
    assign w_rd_valid  = {1'b0, r_idx} < w_limit;
    assign w_div_start = (r_state == ST_RD_DATA) && w_rd_valid && (w_sel.count != '0);
    assign w_abs       = w_sel.sum[SUM_W-1] ? (-w_sel.sum) : w_sel.sum;

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_abs[COUNT_BITS-1:0]),
        .i_divisor  (w_sel.count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // sign of the quotient follows the sum, truncated toward zero
    always_comb begin
        if (!r_ivalid || (r_cnt == '0)) begin
            w_exp = '0;
        end else if (r_sum[SUM_W-1]) begin
            w_exp = -$signed({1'b0, w_quot});
        end else begin
            w_exp = $signed({1'b0, w_quot});
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_index  <= r_idx;
            r_out_ivalid <= r_ivalid;
            r_out_total  <= r_ivalid ? r_cnt : '0;
            r_out_sum    <= r_ivalid ? r_sum : '0;
            r_out_exp    <= w_exp;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_index = r_out_index;
    assign o_out.index_valid  = r_out_ivalid;
    assign o_out.match_total  = r_out_total;
    assign o_out.sign_sum     = r_out_sum;
    assign o_out.expectation  = r_out_exp;
endmodule

>>> src/pse_checker.sv
// Port-level checker for the Pauli shadow accumulator and its bind
`include "pauli_shadow_expectation_accumulator_assert.svh"

module pse_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [7:0]                           i_result_index,
    input logic                                 i_index_valid,
    input logic [pse_pkg::COUNT_BITS-1:0]       i_match_total,
    input logic signed [pse_pkg::SUM_W-1:0]     i_sign_sum,
    input logic signed [pse_pkg::EXP_W-1:0]     i_expectation
);
    import pse_pkg::*;

    // a stalled result stays offered
    `PSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a stalled result keeps its payload
    `PSE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_result_index) && $stable(i_expectation) && $stable(i_sign_sum))

    // an index beyond the entries in use reads as all zero
    `PSE_ASSERT_IMPL(a_bad_index_zero, i_clk, i_rst_n, i_out_valid && !i_index_valid, (i_match_total == '0) && (i_sign_sum == '0) && (i_expectation == '0))

    // no matches means no expectation
    `PSE_ASSERT_IMPL(a_zero_count, i_clk, i_rst_n, i_out_valid && (i_match_total == '0), i_expectation == '0)
endmodule

bind pauli_shadow_expectation_accumulator pse_checker u_pse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_index (o_out.result_index),
    .i_index_valid  (o_out.index_valid),
    .i_match_total  (o_out.match_total),
    .i_sign_sum     (o_out.sign_sum),
    .i_expectation  (o_out.expectation)
);
